@@ hw/rtl/wrms_pkg.sv @@
// Shared types and constants for the windowed RMS meter.
`timescale 1ns / 1ps
`default_nettype none
package wrms_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN           = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESULT_OFFSET  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SAMPLES = 2'd3;

    localparam int ZERO_W   = 10;
    localparam int GAIN_W   = 24;
    localparam int ROFF_W   = 16;
    localparam int WINDOW_W = 11;
    localparam int RMS_W    = 19;
    localparam int FRAC_W   = 16;

    localparam logic [ZERO_W-1:0]   ZERO_RESET   = 10'd512;
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 24'd1729683;
    localparam logic [ROFF_W-1:0]   ROFF_RESET   = 16'd0;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 11'd256;

    typedef struct packed {
        logic accum;
        logic load_div;
        logic div_step;
        logic sqrt_step;
        logic mul;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic win_end;
    } t_status;

endpackage
`default_nettype wire

@@ hw/rtl/wrms_ctrl.sv @@
// Sequencer for accumulation, window-end division, square root and scaling.
`timescale 1ns / 1ps
`default_nettype none
module wrms_ctrl #(
    parameter int ADC_BITS = 10
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    input  wire wrms_pkg::t_status i_status,
    output wrms_pkg::t_cmd        o_cmd
);

    localparam int QW     = 2 * ADC_BITS + wrms_pkg::FRAC_W;
    localparam int R_W    = QW / 2;
    localparam int ITER_W = $clog2(QW);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_SQRT,
        S_MUL,
        S_OUT
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [ITER_W-1:0]   r_iter;
    logic [ITER_W-1:0]   n_iter;
    logic                r_out_valid;
    logic                n_out_valid;
    logic                w_out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_iter      = r_iter;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accum = 1'b1;
                    if (i_status.win_end) begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                o_cmd.load_div = 1'b1;
                n_iter         = ITER_W'(QW - 1);
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_iter == '0) begin
                    n_iter  = ITER_W'(R_W - 1);
                    n_state = S_SQRT;
                end else begin
                    n_iter = r_iter - ITER_W'(1);
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_iter == '0) begin
                    n_state = S_MUL;
                end else begin
                    n_iter = r_iter - ITER_W'(1);
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_iter      <= n_iter;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/wrms_datapath.sv @@
// Configuration registers, square accumulator, divider, square root and scaler.
`timescale 1ns / 1ps
`default_nettype none
module wrms_datapath #(
    parameter int MAX_WINDOW = 1024,
    parameter int ADC_BITS   = 10
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [wrms_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [wrms_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic [ADC_BITS-1:0]               i_sample,
    input  wire wrms_pkg::t_cmd                    i_cmd,
    output wrms_pkg::t_status                      o_status,
    output logic signed [wrms_pkg::RMS_W-1:0]      o_rms_value
);

    localparam int SQ_W    = 2 * ADC_BITS;
    localparam int WMAX    = (MAX_WINDOW < 2047) ? MAX_WINDOW : 2047;
    localparam int COUNT_W = $clog2(WMAX + 1);
    localparam int SUM_W   = SQ_W + COUNT_W;
    localparam int QW      = SQ_W + wrms_pkg::FRAC_W;
    localparam int R_W     = QW / 2;
    localparam int PROD_W  = R_W + wrms_pkg::GAIN_W;
    localparam int CMP_W   = wrms_pkg::WINDOW_W + 1;
    localparam int DIFF_W  = R_W + wrms_pkg::ROFF_W + 1;
    localparam int ZX_W    = ADC_BITS + wrms_pkg::ZERO_W;

    logic [wrms_pkg::ZERO_W-1:0]   r_zero_offset;
    logic [wrms_pkg::GAIN_W-1:0]   r_gain;
    logic [wrms_pkg::ROFF_W-1:0]   r_result_offset;
    logic [wrms_pkg::WINDOW_W-1:0] r_window;

    logic [SUM_W-1:0]   r_sum;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] r_rem;
    logic [COUNT_W-1:0] r_div;
    logic [QW-1:0]      r_qd;
    logic [R_W+1:0]     r_srem;
    logic [R_W-1:0]     r_root;
    logic [PROD_W-1:0]  r_prod;
    logic [wrms_pkg::RMS_W-1:0] r_rms;

    logic [ZX_W-1:0]     w_zx;
    logic [ADC_BITS-1:0] w_z;
    logic [ADC_BITS-1:0] w_mag;
    logic [SQ_W-1:0]     w_sq;
    logic [SUM_W-1:0]    n_sum;
    logic [COUNT_W-1:0]  n_count;
    logic [CMP_W-1:0]    w_win;
    logic [CMP_W-1:0]    w_eff;

    logic [COUNT_W:0]    w_dt;
    logic [COUNT_W:0]    w_dsub;
    logic                w_dge;

    logic [R_W+3:0]      w_st;
    logic [R_W+3:0]      w_trial;
    logic [R_W+3:0]      w_ssub;
    logic                w_sge;

    logic [R_W-1:0]      w_scaled;
    logic [DIFF_W-1:0]   w_diff;

    assign w_zx  = {{ADC_BITS{1'b0}}, r_zero_offset};
    assign w_z   = w_zx[ADC_BITS-1:0];
    assign w_mag = (i_sample >= w_z) ? (i_sample - w_z) : (w_z - i_sample);
    assign w_sq  = SQ_W'(w_mag) * SQ_W'(w_mag);
    assign n_sum   = r_sum + SUM_W'(w_sq);
    assign n_count = r_count + COUNT_W'(1);

    always_comb begin
        w_win = {1'b0, r_window};
        if (w_win == '0) begin
            w_eff = CMP_W'(1);
        end else if (w_win > CMP_W'(WMAX)) begin
            w_eff = CMP_W'(WMAX);
        end else begin
            w_eff = w_win;
        end
    end

    assign o_status.win_end = (CMP_W'(n_count) >= w_eff);

    assign w_dt   = {r_rem, r_qd[QW-1]};
    assign w_dge  = (w_dt >= {1'b0, r_div});
    assign w_dsub = w_dt - {1'b0, r_div};

    assign w_st    = {r_srem, r_qd[QW-1:QW-2]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_sge   = (w_st >= w_trial);
    assign w_ssub  = w_st - w_trial;

    assign w_scaled = r_prod[PROD_W-1:wrms_pkg::GAIN_W];
    assign w_diff   = DIFF_W'(w_scaled) - DIFF_W'(r_result_offset);

    assign o_rms_value = r_rms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_offset   <= wrms_pkg::ZERO_RESET;
            r_gain          <= wrms_pkg::GAIN_RESET;
            r_result_offset <= wrms_pkg::ROFF_RESET;
            r_window        <= wrms_pkg::WINDOW_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wrms_pkg::CFG_ZERO_OFFSET: begin
                    r_zero_offset <= i_cfg_data[wrms_pkg::ZERO_W-1:0];
                end
                wrms_pkg::CFG_GAIN: begin
                    r_gain <= i_cfg_data[wrms_pkg::GAIN_W-1:0];
                end
                wrms_pkg::CFG_RESULT_OFFSET: begin
                    r_result_offset <= i_cfg_data[wrms_pkg::ROFF_W-1:0];
                end
                wrms_pkg::CFG_WINDOW_SAMPLES: begin
                    r_window <= i_cfg_data[wrms_pkg::WINDOW_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
        end else if (i_cmd.accum) begin
            r_sum   <= n_sum;
            r_count <= n_count;
        end else if (i_cmd.load_div) begin
            r_sum   <= '0;
            r_count <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_div) begin
            r_rem  <= r_sum[SUM_W-1:SQ_W];
            r_div  <= r_count;
            r_qd   <= {r_sum[SQ_W-1:0], {wrms_pkg::FRAC_W{1'b0}}};
            r_srem <= '0;
            r_root <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_dge ? w_dsub[COUNT_W-1:0] : w_dt[COUNT_W-1:0];
            r_qd  <= {r_qd[QW-2:0], w_dge};
        end else if (i_cmd.sqrt_step) begin
            r_srem <= w_sge ? w_ssub[R_W+1:0] : w_st[R_W+1:0];
            r_root <= {r_root[R_W-2:0], w_sge};
            r_qd   <= {r_qd[QW-3:0], 2'b00};
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_root) * PROD_W'(r_gain);
        end
        if (i_cmd.load_out) begin
            r_rms <= w_diff[wrms_pkg::RMS_W-1:0];
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/windowed_rms_meter_core.sv @@
// A sample that does not close a window is added to the square accumulator and count; a
// window-closing sample then runs the load, divide, square-root, scale and output states in order.
// Throughput: one sample per cycle, except that the request input is stalled at each window end
// until the result has been loaded into the output register.
// Reset clears the accumulator and count and loads the register reset values.
`timescale 1ns / 1ps
`default_nettype none
module windowed_rms_meter_core #(
    parameter int MAX_WINDOW = 1024,
    parameter int ADC_BITS   = 10
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [wrms_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [wrms_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [ADC_BITS-1:0]             i_sample,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic signed [wrms_pkg::RMS_W-1:0]    o_rms_value
);

    wrms_pkg::t_cmd    w_cmd;
    wrms_pkg::t_status w_status;

    wrms_ctrl #(
        .ADC_BITS (ADC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    wrms_datapath #(
        .MAX_WINDOW (MAX_WINDOW),
        .ADC_BITS   (ADC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (i_sample),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_rms_value (o_rms_value)
    );

endmodule
`default_nettype wire
